// ===== rtl/core/ipow_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipow_pkg
// Shared types and constants of the integer power unit: controller states,
// command and status words between controller and datapath, multiplier
// phases and register map.
// ----------------------------------------------------------------------------
package ipow_pkg;

  localparam int unsigned MUL_W      = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_IDX_ZZ_ABORT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PH_LL,
    PH_LH,
    PH_HL,
    PH_SUM
  } mul_phase_e;

  typedef struct packed {
    logic load;
    logic round_start;
    logic round_update;
    logic finish;
  } ipow_cmd_t;

  typedef struct packed {
    logic special;
    logic exp_zero;
    logic mul_done;
  } ipow_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/ipow_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipow_mul
// Low 64 bits of a 64x64 product, built from three 32x32 partial products
// on one multiplier.
// ----------------------------------------------------------------------------
module ipow_mul
  import ipow_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [MUL_W-1:0] a_i,
  input  wire logic [MUL_W-1:0] b_i,
  output logic                  done_o,
  output logic      [MUL_W-1:0] prod_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  mul_phase_e        phase_q, phase_d;
  logic [MUL_W-1:0]  part_q, part_d;
  logic [MUL_W-1:0]  sum_q, sum_d;
  logic [HALF_W-1:0] op_a, op_b;
  logic [MUL_W-1:0]  pp;

  always_comb begin
    op_a = (phase_q == PH_HL) ? a_i[MUL_W-1:HALF_W] : a_i[HALF_W-1:0];
    op_b = (phase_q == PH_LH) ? b_i[MUL_W-1:HALF_W] : b_i[HALF_W-1:0];
    pp   = MUL_W'(op_a) * MUL_W'(op_b);
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    phase_d = phase_q;
    part_d  = part_q;
    sum_d   = sum_q;
    if (start_i && !busy_q) begin
      busy_d  = 1'b1;
      phase_d = PH_LL;
    end else if (busy_q) begin
      case (phase_q)
        PH_LL: begin
          part_d  = pp;
          phase_d = PH_LH;
        end
        PH_LH: begin
          sum_d   = part_q;
          part_d  = pp;
          phase_d = PH_HL;
        end
        PH_HL: begin
          sum_d   = {sum_q[MUL_W-1:HALF_W] + part_q[HALF_W-1:0], sum_q[HALF_W-1:0]};
          part_d  = pp;
          phase_d = PH_SUM;
        end
        PH_SUM: begin
          sum_d  = {sum_q[MUL_W-1:HALF_W] + part_q[HALF_W-1:0], sum_q[HALF_W-1:0]};
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= PH_LL;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    sum_q  <= sum_d;
  end

  assign done_o = done_q;
  assign prod_o = sum_q;

endmodule
`default_nettype wire

// ===== rtl/core/ipow_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipow_datapath
// Operand capture, special-case decode, square-and-multiply registers with
// two multi-cycle multipliers, sign fix and the output word register.
// ----------------------------------------------------------------------------
module ipow_datapath
  import ipow_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ipow_cmd_t   cmd_i,
  output ipow_sts_t        sts_o,
  input  wire logic [63:0] base_value_i,
  input  wire logic [63:0] exponent_i,
  input  wire logic        zz_abort_i,
  output logic      [63:0] power_o,
  output logic             zero_pow_zero_error_o
);

  localparam logic [DATA_WIDTH-1:0] ONE  = DATA_WIDTH'(1);
  localparam logic [DATA_WIDTH-1:0] ONES = '1;

  logic [DATA_WIDTH-1:0] b_w, e_w;
  logic                  b_neg, e_neg, e_odd;
  logic                  spec_d, spec_err_d;
  logic [DATA_WIDTH-1:0] spec_res_d;

  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [DATA_WIDTH-1:0] mag_q, mag_d;
  logic [DATA_WIDTH-1:0] exp_q, exp_d;
  logic                  spec_q, spec_err_q, neg_fix_q;
  logic [DATA_WIDTH-1:0] spec_res_q;
  logic [DATA_WIDTH-1:0] res;
  logic [63:0]           power_q;
  logic                  err_q;

  logic             mul_a_done, mul_b_done;
  logic [MUL_W-1:0] prod_a, prod_b;

  always_comb begin
    b_w   = base_value_i[DATA_WIDTH-1:0];
    e_w   = exponent_i[DATA_WIDTH-1:0];
    b_neg = b_w[DATA_WIDTH-1];
    e_neg = e_w[DATA_WIDTH-1];
    e_odd = e_w[0];
    spec_d     = 1'b0;
    spec_err_d = 1'b0;
    spec_res_d = '0;
    if (b_w == '0) begin
      spec_d = 1'b1;
      if (e_w == '0) begin
        spec_err_d = zz_abort_i;
        spec_res_d = zz_abort_i ? '0 : ONE;
      end
    end else if (e_neg) begin
      spec_d = 1'b1;
      if (b_w == ONE) begin
        spec_res_d = ONE;
      end else if (b_w == ONES) begin
        spec_res_d = e_odd ? ONES : ONE;
      end
    end
  end

  ipow_mul u_mul_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.round_start),
    .a_i    (MUL_W'(acc_q)),
    .b_i    (MUL_W'(mag_q)),
    .done_o (mul_a_done),
    .prod_o (prod_a)
  );

  ipow_mul u_mul_sqr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.round_start),
    .a_i    (MUL_W'(mag_q)),
    .b_i    (MUL_W'(mag_q)),
    .done_o (mul_b_done),
    .prod_o (prod_b)
  );

  always_comb begin
    acc_d = acc_q;
    mag_d = mag_q;
    exp_d = exp_q;
    if (cmd_i.load) begin
      acc_d = ONE;
      mag_d = b_neg ? ('0 - b_w) : b_w;
      exp_d = e_w;
    end else if (cmd_i.round_update) begin
      acc_d = exp_q[0] ? prod_a[DATA_WIDTH-1:0] : acc_q;
      mag_d = prod_b[DATA_WIDTH-1:0];
      exp_d = exp_q >> 1;
    end
  end

  always_comb begin
    if (spec_q) begin
      res = spec_res_q;
    end else if (neg_fix_q) begin
      res = '0 - acc_q;
    end else begin
      res = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mag_q <= mag_d;
    exp_q <= exp_d;
    if (cmd_i.load) begin
      spec_q     <= spec_d;
      spec_err_q <= spec_err_d;
      spec_res_q <= spec_res_d;
      neg_fix_q  <= b_neg && e_odd;
    end
    if (cmd_i.finish) begin
      power_q <= 64'(signed'(res));
      err_q   <= spec_q && spec_err_q;
    end
  end

  assign sts_o.special         = spec_q;
  assign sts_o.exp_zero        = (exp_q == '0);
  assign sts_o.mul_done        = mul_a_done;
  assign power_o               = power_q;
  assign zero_pow_zero_error_o = err_q;

  a_mul_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_a_done == mul_b_done)
    else $error("multipliers out of step");

  a_update_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round_update |-> mul_a_done)
    else $error("round update without product");

  a_start_needs_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round_start |-> (!spec_q && (exp_q != '0)))
    else $error("round started with nothing left to do");

  a_load_acc_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (acc_q == ONE))
    else $error("accumulator not seeded with one");

endmodule
`default_nettype wire

// ===== rtl/core/ipow_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipow_ctrl
// Sequencer for one word: capture, loop over exponent bits, hand the result
// to the output register and track its valid flag.
// ----------------------------------------------------------------------------
module ipow_ctrl
  import ipow_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output ipow_cmd_t      cmd_o,
  input  wire ipow_sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.special || sts_i.exp_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.round_start = 1'b1;
          state_d           = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sts_i.mul_done) begin
          cmd_o.round_update = 1'b1;
          state_d            = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = cmd_o.finish || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/int64_power_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int64_power_unit
// Signed integer power, wrapping modulo 2^DATA_WIDTH, by square-and-multiply
// on the base magnitude with the sign fixed at the end.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | base_value_i, exponent_i
//   out     | output    | out_valid_o/out_stall_i | power_o, zero_pow_zero_error_o
//   cfg     | input     | APB psel/penable/pready | zero_zero_abort at 0x0
//
// One word at a time, one round per exponent bit up to the highest set bit;
// special cases skip the rounds.
// Each round runs two multipliers in step, each with four steps of its own
// 32x32 multiplier shared by three partial products, plus issue and update cycles.
// Reset clears the sequencer, output valid and zero_zero_abort.
// A new word is taken while a finished result waits; a stalled output
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module int64_power_unit
  import ipow_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [63:0]           base_value_i,
  input  wire logic [63:0]           exponent_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [63:0]           power_o,
  output logic                       zero_pow_zero_error_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic           zz_abort_q, zz_abort_d;
  logic           reg_hit;
  ipow_cmd_t      cmd;
  ipow_sts_t      sts;

  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_IDX_ZZ_ABORT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(zz_abort_q) : '0;

  always_comb begin
    zz_abort_d = zz_abort_q;
    if (psel && penable && pwrite && reg_hit) begin
      zz_abort_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zz_abort_q <= 1'b0;
    end else begin
      zz_abort_q <= zz_abort_d;
    end
  end

  ipow_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ipow_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .base_value_i         (base_value_i),
    .exponent_i           (exponent_i),
    .zz_abort_i           (zz_abort_q),
    .power_o              (power_o),
    .zero_pow_zero_error_o(zero_pow_zero_error_o)
  );

endmodule
`default_nettype wire
